/* src/pl0_lexical_scanner_assert.svh */
// Assertion macros for the PL/0 scanner.
// Used by pl0_back; no other dependencies.
`ifndef PL0_LEXICAL_SCANNER_ASSERT_SVH
`define PL0_LEXICAL_SCANNER_ASSERT_SVH
`ifndef ASSERT_OFF
`define PL0_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PL0_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PL0_ASSERT(label, clk, rst, prop, msg)
`define PL0_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

/* src/pl0_pkg.sv */
// Shared types and constants of the PL/0 scanner.
// No dependencies.
package pl0_pkg;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_INT   = 3'd1,
    M_POINT = 3'd2,
    M_FRAC  = 3'd3,
    M_IDENT = 3'd4,
    M_OP    = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_LT    = 3'd1,
    OP_GT    = 3'd2,
    OP_COLON = 3'd3,
    OP_BANG  = 3'd4
  } op_t;

  localparam logic [5:0] T_DONE    = 6'd0;
  localparam logic [5:0] T_INT     = 6'd1;
  localparam logic [5:0] T_REAL    = 6'd2;
  localparam logic [5:0] T_IDENT   = 6'd3;
  localparam logic [5:0] T_KW0     = 6'd4;
  localparam logic [5:0] T_EQ      = 6'd18;
  localparam logic [5:0] T_NE      = 6'd19;
  localparam logic [5:0] T_LT      = 6'd20;
  localparam logic [5:0] T_LE      = 6'd21;
  localparam logic [5:0] T_GT      = 6'd22;
  localparam logic [5:0] T_GE      = 6'd23;
  localparam logic [5:0] T_COLON   = 6'd24;
  localparam logic [5:0] T_ASSIGN  = 6'd25;
  localparam logic [5:0] T_COMMA   = 6'd26;
  localparam logic [5:0] T_SEMI    = 6'd27;
  localparam logic [5:0] T_PLUS    = 6'd28;
  localparam logic [5:0] T_MINUS   = 6'd29;
  localparam logic [5:0] T_TIMES   = 6'd30;
  localparam logic [5:0] T_SLASH   = 6'd31;
  localparam logic [5:0] T_LPAREN  = 6'd32;
  localparam logic [5:0] T_RPAREN  = 6'd33;
  localparam logic [5:0] T_PROGEND = 6'd34;
  localparam logic [5:0] T_ERROR   = 6'd35;

  localparam int KEYWORD_COUNT = 14;
  localparam int KW_CHARS = 9;

  // Keywords, first byte lowest, zero padded to nine bytes.
  function automatic logic [8*KW_CHARS-1:0] kw_text(input int k);
    logic [8*KW_CHARS-1:0] t;
    t = '0;
    unique case (k)
      0:  t = {8'h00, 8'h00, 8'h00, 8'h00, "t", "s", "n", "o", "c"};
      1:  t = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "r", "a", "v"};
      2:  t = {"e", "r", "u", "d", "e", "c", "o", "r", "p"};
      3:  t = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "l", "l", "a", "c"};
      4:  t = {8'h00, 8'h00, 8'h00, 8'h00, "n", "i", "g", "e", "b"};
      5:  t = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "d", "n", "e"};
      6:  t = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "f", "i"};
      7:  t = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "n", "e", "h", "t"};
      8:  t = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "e", "s", "l", "e"};
      9:  t = {8'h00, 8'h00, 8'h00, 8'h00, "e", "l", "i", "h", "w"};
      10: t = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "o", "d"};
      11: t = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "t", "n", "i"};
      12: t = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "l", "a", "e", "r"};
      13: t = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "i", "f"};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input int k);
    logic [3:0] l;
    unique case (k)
      0, 4, 9: l = 4'd5;
      1, 5, 11: l = 4'd3;
      2: l = 4'd9;
      3, 7, 8, 12: l = 4'd4;
      6, 10, 13: l = 4'd2;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

  // Character class of a byte, computed in the front end.
  typedef enum logic [3:0] {
    C_BLANK, C_NEWLINE, C_DIGIT, C_ALPHA, C_POINT, C_EQ, C_LT, C_GT,
    C_COLON, C_BANG, C_SINGLE, C_OTHER
  } cls_t;

  // Classified request passed from front to back.
  typedef struct packed {
    logic       eoi;
    logic [7:0] ch;
    cls_t       cls;
    logic [3:0] digit;
    logic [5:0] single;
  } citem_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [30:0] ival;
    logic [31:0] mant;
    logic [3:0]  scale;
    logic [63:0] text;
    logic [4:0]  len;
    logic [23:0] line;
    logic        ovf;
    logic        last;
  } tok_t;

endpackage

/* src/pl0_lexical_scanner.sv */
// Top level of the PL/0 lexical scanner: front classifier and back tokenizer.
// Depends on pl0_pkg, pl0_front and pl0_back.
//
// Usage:
//   Input channel in_valid/in_stall carries one source byte (in_char) or an
//   end-of-input mark (end_of_input) per request. The output channel
//   out_valid/out_stall carries tokens; a request gives zero, one or two
//   tokens, and the last of them has last_result set.
//   Throughput: one request per cycle, sustained, as long as tokens drain
//   at one per cycle; a request that makes two tokens leaves one extra token
//   to drain from the back end's output queue.
//   A request that completes a token passes the classifier queue, then the
//   token state machine into a four-entry output queue, before that token
//   appears on the output.
//   Reset (rst, synchronous) empties both queues, returns the scanner to
//   idle between tokens and sets the line counter to one.
//   When the receiver stalls, tokens wait in the output queue; at three queued
//   tokens the back end stops draining the front queue, and in_stall rises.
module pl0_lexical_scanner #(
  parameter int WORD_BUFFER_CHARS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  token_kind,
  output logic [30:0] int_value,
  output logic [31:0] real_mantissa,
  output logic [3:0]  real_scale,
  output logic [63:0] ident_text,
  output logic [4:0]  ident_length,
  output logic [23:0] line_number,
  output logic        value_overflow,
  output logic        last_result
);

  logic            q_valid, q_stall;
  pl0_pkg::citem_t q_item;
  pl0_pkg::tok_t   tok;

  // Classify each byte and hold it in a short queue.
  pl0_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_char, .end_of_input,
    .q_valid, .q_stall, .q_item
  );

  // Advance the token state machine and queue results.
  pl0_back #(.WORD_BUFFER_CHARS(WORD_BUFFER_CHARS)) u_back (
    .clk, .rst, .q_valid, .q_stall, .q_item,
    .out_valid, .out_stall, .out_tok(tok)
  );

  assign token_kind     = tok.kind;
  assign int_value      = tok.ival;
  assign real_mantissa  = tok.mant;
  assign real_scale     = tok.scale;
  assign ident_text     = tok.text;
  assign ident_length   = tok.len;
  assign line_number    = tok.line;
  assign value_overflow = tok.ovf;
  assign last_result    = tok.last;

endmodule

/* src/pl0_front.sv */
// Front end: input register and byte classifier of the PL/0 scanner.
// Depends on pl0_pkg.
module pl0_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char,
  input  logic               end_of_input,
  output logic               q_valid,
  input  logic               q_stall,
  output pl0_pkg::citem_t    q_item
);

  pl0_pkg::citem_t c;

  always_comb begin
    c = '0;
    c.eoi = end_of_input;
    c.ch = in_char;
    c.digit = in_char[3:0];
    c.single = pl0_pkg::T_ERROR;
    if (in_char == " " || in_char == 8'h09) c.cls = pl0_pkg::C_BLANK;
    else if (in_char == 8'h0A || in_char == 8'h0D) c.cls = pl0_pkg::C_NEWLINE;
    else if (in_char >= "0" && in_char <= "9") c.cls = pl0_pkg::C_DIGIT;
    else if ((in_char >= "a" && in_char <= "z") || (in_char >= "A" && in_char <= "Z"))
      c.cls = pl0_pkg::C_ALPHA;
    else begin
      c.cls = pl0_pkg::C_SINGLE;
      unique case (in_char)
        ".": c.cls = pl0_pkg::C_POINT;
        "=": c.cls = pl0_pkg::C_EQ;
        "<": c.cls = pl0_pkg::C_LT;
        ">": c.cls = pl0_pkg::C_GT;
        ":": c.cls = pl0_pkg::C_COLON;
        "!": c.cls = pl0_pkg::C_BANG;
        ",": c.single = pl0_pkg::T_COMMA;
        ";": c.single = pl0_pkg::T_SEMI;
        "+": c.single = pl0_pkg::T_PLUS;
        "-": c.single = pl0_pkg::T_MINUS;
        "*": c.single = pl0_pkg::T_TIMES;
        "/": c.single = pl0_pkg::T_SLASH;
        "(": c.single = pl0_pkg::T_LPAREN;
        ")": c.single = pl0_pkg::T_RPAREN;
        "$": c.single = pl0_pkg::T_PROGEND;
        default: c.cls = pl0_pkg::C_OTHER;
      endcase
    end
  end

  // Two-entry queue toward the back end.
  pl0_pkg::citem_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;

  assign in_stall = (cnt == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt != 2'd0);
  assign pop = q_valid && !q_stall;
  assign q_item = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= c;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* src/pl0_back.sv */
// Back end: token state machine, accumulators, keyword match, output skid.
// Depends on pl0_pkg and the assertion macro header.
`include "pl0_lexical_scanner_assert.svh"
module pl0_back #(
  parameter int WORD_BUFFER_CHARS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_stall,
  input  pl0_pkg::citem_t q_item,
  output logic            out_valid,
  input  logic            out_stall,
  output pl0_pkg::tok_t   out_tok
);
  localparam int LW = $clog2(WORD_BUFFER_CHARS + 1);
  localparam int IW = $clog2(WORD_BUFFER_CHARS);

  pl0_pkg::mode_t mode, mode_next;
  pl0_pkg::op_t   pop_r, pop_next;
  logic [7:0]  wbuf [WORD_BUFFER_CHARS];
  logic [LW-1:0] wlen, wlen_next;
  logic [31:0] acc, acc_next;
  logic [3:0]  frac, frac_next;
  logic        sat, sat_next;
  logic [23:0] line, line_next;
  logic        wr_en;

  // Two output slots per request, held in a four-entry queue.
  pl0_pkg::tok_t oq [4];
  logic [1:0] owp, orp;
  logic [2:0] ocnt;
  pl0_pkg::tok_t r0, r1;
  logic [1:0] nres;

  assign q_stall = (ocnt > 3'd2);
  logic take;
  assign take = q_valid && !q_stall;

  // Keyword match over buffered word.
  logic [5:0] kw;
  always_comb begin
    kw = '0;
    for (int k = 0; k < pl0_pkg::KEYWORD_COUNT; k++) begin
      logic ok;
      logic [8*pl0_pkg::KW_CHARS-1:0] kt;
      kt = pl0_pkg::kw_text(k);
      ok = !sat && (wlen == LW'(pl0_pkg::kw_len(k)));
      for (int i = 0; i < pl0_pkg::KW_CHARS; i++)
        if (i < int'(pl0_pkg::kw_len(k)) && wbuf[i] != kt[8*i +: 8])
          ok = 1'b0;
      if (ok && kw == '0) kw = 6'(pl0_pkg::T_KW0 + 6'(k));
    end
  end

  logic [63:0] txt;
  always_comb begin
    txt = '0;
    for (int i = 0; i < 8; i++)
      if (LW'(i) < wlen) txt[8*i +: 8] = wbuf[i];
  end

  function automatic pl0_pkg::tok_t simple(input logic [5:0] k, input logic [23:0] ln);
    pl0_pkg::tok_t t;
    t = '0;
    t.kind = k;
    t.line = ln;
    return t;
  endfunction

  logic [35:0] t10;
  logic        fl_v;
  pl0_pkg::tok_t fl;
  logic        consumed;
  logic        st_v;
  pl0_pkg::tok_t st;

  always_comb begin
    // Flush token of the current lexeme.
    fl_v = 1'b1;
    fl = simple(pl0_pkg::T_ERROR, line);
    unique case (mode)
      pl0_pkg::M_INT: begin
        fl.kind = pl0_pkg::T_INT;
        fl.ival = acc[31] ? 31'h7FFFFFFF : acc[30:0];
        fl.ovf = acc[31] | sat;
      end
      pl0_pkg::M_POINT: ;
      pl0_pkg::M_FRAC: begin
        fl.kind = pl0_pkg::T_REAL;
        fl.mant = acc;
        fl.scale = frac;
        fl.ovf = sat;
      end
      pl0_pkg::M_IDENT: begin
        if (kw != '0) fl.kind = kw;
        else begin
          fl.kind = pl0_pkg::T_IDENT;
          fl.text = txt;
          fl.len = 5'(wlen);
          fl.ovf = sat;
        end
      end
      pl0_pkg::M_OP: begin
        unique case (pop_r)
          pl0_pkg::OP_LT: fl.kind = pl0_pkg::T_LT;
          pl0_pkg::OP_GT: fl.kind = pl0_pkg::T_GT;
          pl0_pkg::OP_COLON: fl.kind = pl0_pkg::T_COLON;
          default: fl.kind = pl0_pkg::T_ERROR;
        endcase
      end
      default: fl_v = 1'b0;
    endcase
  end

  always_comb begin
    logic [31:0] base;
    logic        frac_mode;
    mode_next = mode;
    pop_next = pop_r;
    wlen_next = wlen;
    acc_next = acc;
    frac_next = frac;
    sat_next = sat;
    line_next = line;
    wr_en = 1'b0;
    consumed = 1'b0;
    st_v = 1'b0;
    st = simple(pl0_pkg::T_ERROR, line);
    frac_mode = (mode == pl0_pkg::M_POINT || mode == pl0_pkg::M_FRAC);
    base = acc;
    if (!q_item.eoi) begin
      unique case (mode)
        pl0_pkg::M_INT: consumed = (q_item.cls == pl0_pkg::C_DIGIT) ||
                                   (q_item.cls == pl0_pkg::C_POINT);
        pl0_pkg::M_POINT, pl0_pkg::M_FRAC: consumed = (q_item.cls == pl0_pkg::C_DIGIT);
        pl0_pkg::M_IDENT: consumed = (q_item.cls == pl0_pkg::C_DIGIT) ||
                                     (q_item.cls == pl0_pkg::C_ALPHA);
        pl0_pkg::M_OP: consumed = (q_item.cls == pl0_pkg::C_EQ);
        default: consumed = 1'b0;
      endcase
    end
    if (!consumed) begin
      base = '0;
      frac_mode = 1'b0;
    end
    t10 = {4'd0, base} * 36'd10 + {32'd0, q_item.digit};
    if (q_item.eoi) begin
      mode_next = pl0_pkg::M_IDLE; pop_next = pl0_pkg::OP_NONE;
      wlen_next = '0; acc_next = '0; frac_next = '0; sat_next = 1'b0;
      st_v = 1'b1;
      st = simple(pl0_pkg::T_DONE, line);
    end else if (consumed) begin
      if (mode == pl0_pkg::M_OP) begin
        st_v = 1'b1;
        unique case (pop_r)
          pl0_pkg::OP_LT: st.kind = pl0_pkg::T_LE;
          pl0_pkg::OP_GT: st.kind = pl0_pkg::T_GE;
          pl0_pkg::OP_COLON: st.kind = pl0_pkg::T_ASSIGN;
          default: st.kind = pl0_pkg::T_NE;
        endcase
        mode_next = pl0_pkg::M_IDLE; pop_next = pl0_pkg::OP_NONE;
      end else if (mode == pl0_pkg::M_IDENT) begin
        if (wlen < LW'(WORD_BUFFER_CHARS)) begin
          wr_en = 1'b1; wlen_next = wlen + LW'(1);
        end else sat_next = 1'b1;
      end else if (q_item.cls == pl0_pkg::C_POINT) begin
        mode_next = pl0_pkg::M_POINT;
      end else if (frac_mode) begin
        mode_next = pl0_pkg::M_FRAC;
        if (frac == 4'd15 || t10[35:32] != 4'd0) sat_next = 1'b1;
        else begin acc_next = t10[31:0]; frac_next = frac + 4'd1; end
      end else begin
        if (t10[35:32] != 4'd0) begin acc_next = '1; sat_next = 1'b1; end
        else acc_next = t10[31:0];
      end
    end else begin
      // Close the lexeme and start on this byte.
      mode_next = pl0_pkg::M_IDLE; pop_next = pl0_pkg::OP_NONE;
      wlen_next = '0; acc_next = '0; frac_next = '0; sat_next = 1'b0;
      unique case (q_item.cls)
        pl0_pkg::C_BLANK: ;
        pl0_pkg::C_NEWLINE: if (line != 24'hFFFFFF) line_next = line + 24'd1;
        pl0_pkg::C_DIGIT: begin
          mode_next = pl0_pkg::M_INT; acc_next = t10[31:0];
        end
        pl0_pkg::C_ALPHA: begin
          mode_next = pl0_pkg::M_IDENT; wr_en = 1'b1; wlen_next = LW'(1);
        end
        pl0_pkg::C_LT: begin mode_next = pl0_pkg::M_OP; pop_next = pl0_pkg::OP_LT; end
        pl0_pkg::C_GT: begin mode_next = pl0_pkg::M_OP; pop_next = pl0_pkg::OP_GT; end
        pl0_pkg::C_COLON: begin
          mode_next = pl0_pkg::M_OP; pop_next = pl0_pkg::OP_COLON;
        end
        pl0_pkg::C_BANG: begin mode_next = pl0_pkg::M_OP; pop_next = pl0_pkg::OP_BANG; end
        pl0_pkg::C_EQ: begin st_v = 1'b1; st.kind = pl0_pkg::T_EQ; end
        pl0_pkg::C_SINGLE: begin st_v = 1'b1; st.kind = q_item.single; end
        default: st_v = 1'b1;
      endcase
    end
  end

  logic do_flush;
  assign do_flush = fl_v && !consumed;

  always_comb begin
    r0 = do_flush ? fl : st;
    r1 = st;
    nres = 2'({1'b0, do_flush} + {1'b0, st_v});
    r0.last = (nres == 2'd1);
    r1.last = 1'b1;
  end

  logic opop;
  assign out_valid = (ocnt != 3'd0);
  assign opop = out_valid && !out_stall;
  assign out_tok = oq[orp];

  always_ff @(posedge clk) begin
    if (take && wr_en) wbuf[wlen[IW-1:0]] <= q_item.ch;
    if (take && nres != 2'd0) oq[owp] <= r0;
    if (take && nres == 2'd2) oq[owp + 2'd1] <= r1;
    if (rst) begin
      mode <= pl0_pkg::M_IDLE;
      pop_r <= pl0_pkg::OP_NONE;
      wlen <= '0; acc <= '0; frac <= '0; sat <= 1'b0;
      line <= 24'd1;
      owp <= '0; orp <= '0; ocnt <= '0;
    end else begin
      if (take) begin
        mode <= mode_next; pop_r <= pop_next; wlen <= wlen_next;
        acc <= acc_next; frac <= frac_next; sat <= sat_next; line <= line_next;
        owp <= owp + nres;
      end
      if (opop) orp <= orp + 2'd1;
      ocnt <= ocnt + (take ? {1'b0, nres} : 3'd0) - {2'd0, opop};
    end
  end

  `PL0_ASSERT(a_oq_bound, clk, rst, ocnt <= 3'd4, "output queue overrun")
  `PL0_ASSERT(a_no_take_full, clk, rst, (ocnt > 3'd2) |-> !take, "request taken while full")
  `PL0_ASSERT(a_wlen_bound, clk, rst, wlen <= LW'(WORD_BUFFER_CHARS), "word length too large")
  `PL0_ASSERT(a_line_nonzero, clk, rst, line != 24'd0, "line counter zero")

endmodule
